// File: rtl/pslu_pkg.sv
package pslu_pkg;

  localparam int MAX_SECTION_BYTES_DEF = 4096;
  localparam int HEADER_BYTES          = 8;
  localparam int LEN_W                 = 12;
  localparam int PID_W                 = 13;
  localparam int SID_W                 = 16;
  localparam int CNT_CMP_W             = 13;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_LEN_ERR   = 2'd2
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } byte_slot_t;

endpackage

// File: rtl/pslu_in_stage.sv
module pslu_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic                 advance,
  output pslu_pkg::byte_slot_t slot
);

  logic       valid;
  logic [7:0] data;
  logic       last;

  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_byte;
      last <= last_byte;
    end
  end

  assign slot.valid = valid;
  assign slot.data  = data;
  assign slot.last  = last;

endmodule

// File: rtl/pslu_parser.sv
module pslu_parser #(
  parameter int MAX_SECTION_BYTES = pslu_pkg::MAX_SECTION_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pslu_pkg::byte_slot_t          slot,
  output logic                          advance,
  input  logic                          cfg_we,
  input  logic [pslu_pkg::SID_W-1:0]    cfg_sid,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [pslu_pkg::PID_W-1:0]    map_pid
);

  localparam int POS_W = $clog2(MAX_SECTION_BYTES + 1);
  localparam int CMP_W = pslu_pkg::CNT_CMP_W + 1;

  logic [pslu_pkg::SID_W-1:0] target_sid;
  logic [POS_W-1:0]           byte_position, byte_position_next;
  logic [pslu_pkg::LEN_W-1:0] declared_length, declared_length_next;
  logic [23:0]                entry_bytes, entry_bytes_next;
  logic                       match_seen, match_seen_next;
  logic [pslu_pkg::PID_W-1:0] matched_pid, matched_pid_next;
  logic                       overflow_seen, overflow_seen_next;
  pslu_pkg::status_t          res_status;
  logic [pslu_pkg::PID_W-1:0] res_pid;

  assign advance = slot.valid && (!slot.last || !out_valid || out_ready);

  always_comb begin
    byte_position_next   = byte_position;
    declared_length_next = declared_length;
    entry_bytes_next     = entry_bytes;
    match_seen_next      = match_seen;
    matched_pid_next     = matched_pid;
    overflow_seen_next   = overflow_seen;
    if (byte_position >= POS_W'(MAX_SECTION_BYTES)) begin
      overflow_seen_next = 1'b1;
    end else begin
      if (byte_position == POS_W'(1)) begin
        declared_length_next = {slot.data[3:0], declared_length[7:0]};
      end else if (byte_position == POS_W'(2)) begin
        declared_length_next = {declared_length[11:8], slot.data};
      end else if (byte_position >= POS_W'(pslu_pkg::HEADER_BYTES)) begin
        if (byte_position[1:0] != 2'd3) begin
          entry_bytes_next = {entry_bytes[15:0], slot.data};
        end else if ((CMP_W'(byte_position) + CMP_W'(2)) <= CMP_W'(declared_length)
                     && !match_seen) begin
          if (entry_bytes[23:8] == target_sid) begin
            matched_pid_next = {entry_bytes[4:0], slot.data};
            match_seen_next  = 1'b1;
          end
        end
      end
      byte_position_next = byte_position + POS_W'(1);
    end

    res_pid = '0;
    if (overflow_seen_next || (pslu_pkg::CNT_CMP_W'(byte_position_next) !=
        pslu_pkg::CNT_CMP_W'(declared_length_next) + pslu_pkg::CNT_CMP_W'(3))) begin
      res_status = pslu_pkg::ST_LEN_ERR;
    end else if (match_seen_next) begin
      res_status = pslu_pkg::ST_FOUND;
      res_pid    = matched_pid_next;
    end else begin
      res_status = pslu_pkg::ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sid <= '0;
    end else if (cfg_we) begin
      target_sid <= cfg_sid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      declared_length <= '0;
      entry_bytes     <= '0;
      match_seen      <= 1'b0;
      matched_pid     <= '0;
      overflow_seen   <= 1'b0;
    end else if (advance) begin
      if (slot.last) begin
        byte_position   <= '0;
        declared_length <= '0;
        entry_bytes     <= '0;
        match_seen      <= 1'b0;
        matched_pid     <= '0;
        overflow_seen   <= 1'b0;
      end else begin
        byte_position   <= byte_position_next;
        declared_length <= declared_length_next;
        entry_bytes     <= entry_bytes_next;
        match_seen      <= match_seen_next;
        matched_pid     <= matched_pid_next;
        overflow_seen   <= overflow_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && slot.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && slot.last) begin
      status  <= res_status;
      map_pid <= res_pid;
    end
  end

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3))
    else $error("illegal status code");

  a_pid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != pslu_pkg::ST_FOUND) |-> (map_pid == '0))
    else $error("map_pid nonzero without a match");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_W'(MAX_SECTION_BYTES))
    else $error("byte count past section bound");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && slot.last) |=> (byte_position == '0 && !match_seen && !overflow_seen))
    else $error("section state not cleared after last byte");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (advance && slot.last) |=> out_valid)
    else $error("last byte did not produce a result");

endmodule

// File: rtl/pat_service_pid_lookup_unit.sv
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready   | data_byte[7:0], last_byte
// out     | out | out_valid / out_ready | status[1:0], map_pid[12:0]
// cfg     | in  | cfg_valid / cfg_ready | program_num[15:0]
//
// One byte per cycle unless a last byte is held; a byte passes input register,
// then parse logic into the result register, loaded as the last byte advances.
// Sync active-high reset clears section state, valids and the program number.
// A waiting result stalls a following last byte, and the bytes behind it wait too;
// cfg_ready is always high.
module pat_service_pid_lookup_unit #(
  parameter int MAX_SECTION_BYTES = pslu_pkg::MAX_SECTION_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [pslu_pkg::PID_W-1:0] map_pid,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pslu_pkg::SID_W-1:0] program_num
);

  pslu_pkg::byte_slot_t slot;
  logic                 advance;

  assign cfg_ready = 1'b1;

  pslu_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .advance   (advance),
    .slot      (slot)
  );

  pslu_parser #(
    .MAX_SECTION_BYTES (MAX_SECTION_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .slot      (slot),
    .advance   (advance),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_sid   (program_num),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .map_pid   (map_pid)
  );

endmodule

// File: verif/tb_pat_service_pid_lookup_unit.sv
`timescale 1ns / 100ps

module tb_pat_service_pid_lookup_unit;

  typedef struct {
    pslu_pkg::status_t          st;
    logic [pslu_pkg::PID_W-1:0] pid;
  } pmt_lookup_t;

  class pmt_pid_scoreboard;
    logic [pslu_pkg::SID_W-1:0] sid;
    int                         count;
    logic [pslu_pkg::LEN_W-1:0] sec_len;
    logic [23:0]                entry_hold;
    bit                         hit;
    logic [pslu_pkg::PID_W-1:0] hit_pid;
    bit                         too_long;
    pmt_lookup_t                lookups_due[$];
    int                         errors;
    int                         lookups_seen;

    function new();
      sid = '0;
      errors = 0;
      lookups_seen = 0;
      restart();
    endfunction

    function void restart();
      count = 0;
      sec_len = '0;
      entry_hold = '0;
      hit = 1'b0;
      hit_pid = '0;
      too_long = 1'b0;
    endfunction

    function void note_byte(logic [7:0] b, logic l);
      pmt_lookup_t r;
      if (count >= pslu_pkg::MAX_SECTION_BYTES_DEF) begin
        too_long = 1'b1;
      end else begin
        if (count == 1) begin
          sec_len[11:8] = b[3:0];
        end else if (count == 2) begin
          sec_len[7:0] = b;
        end else if (count >= pslu_pkg::HEADER_BYTES) begin
          if (((count - pslu_pkg::HEADER_BYTES) % 4) != 3) begin
            entry_hold = {entry_hold[15:0], b};
          end else if (count + 2 <= int'(sec_len) && !hit && entry_hold[23:8] == sid) begin
            // entry ends before the CRC; first match wins
            hit = 1'b1;
            hit_pid = {entry_hold[4:0], b};
          end
        end
        count++;
      end
      if (l) begin
        r.pid = '0;
        if (too_long || count != int'(sec_len) + 3) begin
          r.st = pslu_pkg::ST_LEN_ERR;
        end else if (hit) begin
          r.st = pslu_pkg::ST_FOUND;
          r.pid = hit_pid;
        end else begin
          r.st = pslu_pkg::ST_NOT_FOUND;
        end
        lookups_due.insert(lookups_due.size(), r);
        restart();
      end
    endfunction

    function void note_error(string s);
      errors++;
      if (errors <= 10) $display("%0t mismatch: %s", $time, s);
    endfunction

    function void check_result(logic [1:0] st, logic [pslu_pkg::PID_W-1:0] pid);
      pmt_lookup_t e;
      lookups_seen++;
      if (lookups_due.size() == 0) begin
        note_error($sformatf("unexpected result status %0d map_pid 0x%0h", st, pid));
        return;
      end
      e = lookups_due.pop_front();
      if (st !== 2'(e.st) || pid !== e.pid) begin
        note_error($sformatf("got status %0d map_pid 0x%0h, expected status %0d map_pid 0x%0h",
                             st, pid, e.st, e.pid));
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 data_byte = '0;
  logic                       last_byte = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 status;
  logic [pslu_pkg::PID_W-1:0] map_pid;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [pslu_pkg::SID_W-1:0] program_num = '0;

  int                send_idle_pct = 13;
  int                recv_idle_pct = 77;
  bit                long_hold_done = 1'b0;
  logic [7:0]        section_q[$];
  pmt_pid_scoreboard sb = new();

  always #6 clk = ~clk;

  pat_service_pid_lookup_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .map_pid     (map_pid),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .program_num (program_num)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(status, map_pid);
  end

  // result side; one long hold-off so the block backs up into its input
  initial begin
    forever begin
      @(posedge clk);
      if (!long_hold_done && sb.lookups_seen >= 8) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void append_byte(input logic [7:0] b);
    section_q.insert(section_q.size(), b);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic l);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, l);
  endtask

  task automatic send_section();
    foreach (section_q[i]) push_byte(section_q[i], i == section_q.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.lookups_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_sid(input logic [pslu_pkg::SID_W-1:0] v);
    cfg_valid <= 1'b1;
    program_num <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.sid = v;
    cfg_valid <= 1'b0;
  endtask

  // header, n program entries, optional partial entry, CRC
  task automatic build_section(input int n, input int extra, input int match_pct);
    logic [pslu_pkg::LEN_W-1:0] len;
    logic [pslu_pkg::SID_W-1:0] num;
    len = pslu_pkg::LEN_W'(9 + 4 * n + extra);
    section_q.delete();
    append_byte(8'($urandom));
    append_byte({4'($urandom), len[11:8]});
    append_byte(len[7:0]);
    repeat (5) append_byte(8'($urandom));
    repeat (n) begin
      num = ($urandom_range(99) < match_pct) ? sb.sid : pslu_pkg::SID_W'($urandom);
      append_byte(num[15:8]);
      append_byte(num[7:0]);
      repeat (2) append_byte(8'($urandom));
    end
    num = $urandom_range(1) ? sb.sid : pslu_pkg::SID_W'($urandom);
    for (int k = 0; k < extra; k++) begin
      append_byte((k < 2) ? num[15 - 8 * k -: 8] : 8'($urandom));
    end
    repeat (4) append_byte(8'($urandom));
  endtask

  task automatic build_random_section();
    int                         kind;
    logic [pslu_pkg::LEN_W-1:0] len;
    kind = $urandom_range(11);
    build_section($urandom_range(5), (kind == 0) ? $urandom_range(1, 3) : 0, 30);
    case (kind)
      1: begin
        repeat ($urandom_range(1, 4)) begin
          if (section_q.size() > 1) void'(section_q.pop_back());
        end
      end
      2: begin
        repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
      end
      3: begin
        len = pslu_pkg::LEN_W'($urandom);
        section_q[1] = {section_q[1][7:4], len[11:8]};
        section_q[2] = len[7:0];
      end
      4: begin
        section_q.delete();
        repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic run_random(input int nbytes);
    int sent;
    sent = 0;
    while (sent < nbytes) begin
      build_random_section();
      sent += section_q.size();
      send_section();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset service id is 0
    section_q = '{8'h00, 8'hf0, 8'h00};
    send_section();
    section_q = '{8'h5a};
    send_section();
    section_q = '{8'hff, 8'hf0, 8'd13, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                  8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    send_section();
    drain();

    write_sid(16'hffff);
    run_random(340);
    drain();

    send_idle_pct = 77;
    recv_idle_pct = 13;
    write_sid(pslu_pkg::SID_W'($urandom));
    run_random(340);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_sid(pslu_pkg::SID_W'($urandom));
    run_random(340);
    drain();

    if (sb.errors == 0 && sb.lookups_due.size() == 0) begin
      $display("tb_pat_service_pid_lookup_unit: clean");
    end else begin
      $display("tb_pat_service_pid_lookup_unit: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_pat_service_pid_lookup_unit: errors");
    $finish;
  end

endmodule
